FILE: sv/alfg_pkg.sv
// alfg_pkg: shared types and constants for the argb linear fade generator
// no dependencies; used by alfg_blend and argb_linear_fade_generator_unit
`timescale 1ns / 1ps

package alfg_pkg;

  // one input request
  typedef struct packed {
    logic        command;
    logic [15:0] elapsed_ms;
  } in_t;

  // one result
  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [3:0] write_mask;
    logic       pass_wrapped;
    logic       finished;
  } out_t;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_START    = 3'd1;
  localparam logic [2:0] REG_END      = 3'd2;
  localparam logic [2:0] REG_MASK     = 3'd3;
  localparam logic [2:0] REG_BOUNCE   = 3'd4;
  localparam logic [2:0] REG_RESTART  = 3'd5;

  localparam logic [23:0] DURATION_RESET = 24'd1000;
  localparam logic [31:0] START_RESET    = 32'h0000_0000;
  localparam logic [31:0] END_RESET      = 32'hFFFF_FFFF;
  localparam logic [3:0]  MASK_RESET     = 4'hF;

  // request to the channel interpolator
  typedef struct packed {
    logic        go;
    logic [7:0]  from_c;
    logic [7:0]  to_c;
    logic [23:0] rem;
    logic [23:0] dur;
  } blend_req_t;

  // reply from the channel interpolator
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] value;
  } blend_rsp_t;

endpackage

FILE: sv/alfg_blend.sv
// alfg_blend: iterative interpolator for one 8-bit colour channel
// a multiply state, eight restoring divide steps and a result state; uses alfg_pkg
`timescale 1ns / 1ps

module alfg_blend
  import alfg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  blend_req_t req,
  output blend_rsp_t rsp
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_FIN} bstate_t;

  bstate_t     state;
  logic        neg;
  logic [7:0]  mag;
  logic [7:0]  to_c;
  logic [31:0] partial;
  logic [30:0] div_sh;
  logic [7:0]  qa;
  logic [2:0]  bitcnt;
  logic        done;
  logic [7:0]  value;

  logic        ge;
  logic        dur_zero;
  logic [8:0]  sum;

  assign ge       = partial >= {1'b0, div_sh};
  assign dur_zero = (req.dur == 24'd0);

  // negative numerator rounds towards minus infinity
  always_comb begin
    if (dur_zero) begin
      sum = {1'b0, to_c};
    end else if (neg) begin
      sum = {1'b0, to_c} - {1'b0, qa} - {8'b0, |partial};
    end else begin
      sum = {1'b0, to_c} + {1'b0, qa};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == B_FIN);
      case (state)
        B_IDLE: begin
          if (req.go) begin
            neg   <= req.from_c < req.to_c;
            mag   <= (req.from_c < req.to_c) ? (req.to_c - req.from_c)
                                             : (req.from_c - req.to_c);
            to_c  <= req.to_c;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          partial <= {24'b0, mag} * {8'b0, req.rem};
          div_sh  <= {req.dur, 7'b0};
          qa      <= 8'd0;
          bitcnt  <= 3'd7;
          state   <= B_DIV;
        end
        B_DIV: begin
          if (ge) begin
            partial <= partial - {1'b0, div_sh};
          end
          qa     <= {qa[6:0], ge};
          div_sh <= {1'b0, div_sh[30:1]};
          bitcnt <= bitcnt - 3'd1;
          if (bitcnt == 3'd0) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          value <= sum[7:0];
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign rsp.busy  = (state != B_IDLE);
  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

FILE: sv/argb_linear_fade_generator_unit.sv
// argb_linear_fade_generator_unit: timed linear argb fade, top level
// depends on alfg_pkg and alfg_blend
// sequence: a start request gives no result; a tick while running passes through a
//   remaining-time state, the four channels in turn in the shared interpolator and
//   a wrap state that loads the result
// flow: one request at a time, set by the single shared multiply/divide unit;
//   after a tick the next request is taken once its result is loaded, later
//   while an earlier result is still waiting
// reset: rst synchronous, active high; registers to their defaults, fade stopped
`timescale 1ns / 1ps

module argb_linear_fade_generator_unit
  import alfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  in_t         req_data,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output out_t        rsp_data,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {S_IDLE, S_TIME, S_CHAN, S_WAIT, S_DONE} state_t;

  // configuration registers
  logic [23:0] duration_ms;
  logic [31:0] start_color;
  logic [31:0] end_color;
  logic [3:0]  channel_mask;
  logic        bounce_loop;
  logic        restart_loop;

  // fade state
  logic [23:0] time_left;
  logic [31:0] from_now;
  logic [31:0] to_now;
  logic        running;

  // sequencer
  state_t      state;
  logic [1:0]  ch;
  logic [23:0] rem;
  logic [7:0]  chan_val [4];

  logic        req_fire;
  logic        cfg_we;
  logic        out_free;
  logic        pass_end;
  logic [23:0] time_left_next;
  blend_req_t  blend_req;
  blend_rsp_t  blend_rsp;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign pass_end  = (time_left == 24'd0);

  // saturating subtract of the elapsed time
  assign time_left_next = (time_left > {8'b0, req_data.elapsed_ms})
                        ? (time_left - {8'b0, req_data.elapsed_ms}) : 24'd0;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms  <= DURATION_RESET;
      start_color  <= START_RESET;
      end_color    <= END_RESET;
      channel_mask <= MASK_RESET;
      bounce_loop  <= 1'b0;
      restart_loop <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_DURATION: duration_ms  <= pwdata[23:0];
        REG_START:    start_color  <= pwdata;
        REG_END:      end_color    <= pwdata;
        REG_MASK:     channel_mask <= pwdata[3:0];
        REG_BOUNCE:   bounce_loop  <= pwdata[0];
        REG_RESTART:  restart_loop <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[4:2])
      REG_DURATION: prdata = {8'b0, duration_ms};
      REG_START:    prdata = start_color;
      REG_END:      prdata = end_color;
      REG_MASK:     prdata = {28'b0, channel_mask};
      REG_BOUNCE:   prdata = {31'b0, bounce_loop};
      REG_RESTART:  prdata = {31'b0, restart_loop};
      default:      prdata = 32'b0;
    endcase
  end

  // shared channel interpolator, channels taken alpha first down to blue
  assign blend_req.go     = (state == S_CHAN);
  assign blend_req.from_c = from_now[{ch, 3'b000} +: 8];
  assign blend_req.to_c   = to_now[{ch, 3'b000} +: 8];
  assign blend_req.rem    = rem;
  assign blend_req.dur    = duration_ms;

  alfg_blend u_blend (
    .clk (clk),
    .rst (rst),
    .req (blend_req),
    .rsp (blend_rsp)
  );

  // main sequencer, fade state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      time_left <= 24'd0;
      from_now  <= 32'd0;
      to_now    <= 32'd0;
      rsp_valid <= 1'b0;
      ch        <= 2'd3;
    end else begin
      // a new result can only be loaded once the old one has gone
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req_data.command == CMD_START) begin
              time_left <= duration_ms;
              from_now  <= start_color;
              to_now    <= end_color;
              running   <= 1'b1;
            end else if (running) begin
              // tick while stopped is dropped
              time_left <= time_left_next;
              state     <= S_TIME;
            end
          end
        end
        S_TIME: begin
          // ratio saturates at one when the duration was lowered mid-fade
          rem   <= (time_left > duration_ms) ? duration_ms : time_left;
          ch    <= 2'd3;
          state <= S_CHAN;
        end
        S_CHAN: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (blend_rsp.done) begin
            chan_val[ch] <= blend_rsp.value;
            if (ch == 2'd0) begin
              state <= S_DONE;
            end else begin
              ch    <= ch - 2'd1;
              state <= S_CHAN;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid               <= 1'b1;
            rsp_data.alpha_out      <= channel_mask[3] ? chan_val[3] : 8'd0;
            rsp_data.red_out        <= channel_mask[2] ? chan_val[2] : 8'd0;
            rsp_data.green_out      <= channel_mask[1] ? chan_val[1] : 8'd0;
            rsp_data.blue_out       <= channel_mask[0] ? chan_val[0] : 8'd0;
            rsp_data.write_mask     <= channel_mask;
            rsp_data.pass_wrapped   <= pass_end && (bounce_loop || restart_loop);
            rsp_data.finished       <= pass_end && !bounce_loop && !restart_loop;
            // end of pass: bounce beats restart, else stop
            if (pass_end) begin
              if (bounce_loop) begin
                from_now              <= to_now;
                to_now                <= from_now;
                time_left             <= duration_ms;
              end else if (restart_loop) begin
                time_left             <= duration_ms;
              end else begin
                running               <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result never both wraps and finishes
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.pass_wrapped && rsp_data.finished))
    else $error("result both wrapped and finished");

  // interpolator is quiet whenever the block takes requests
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!blend_rsp.done && !blend_rsp.busy))
    else $error("interpolator active while idle");

  // a tick while stopped starts no work
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req_data.command == CMD_TICK) && !running) |=> (state == S_IDLE))
    else $error("tick while stopped started work");

  // a masked alpha channel reads as zero
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.write_mask[3]) |-> (rsp_data.alpha_out == 8'd0))
    else $error("masked alpha not zero");

endmodule

FILE: tb/alfg_checker.sv
// alfg_checker: colour predictor and result checker for the argb fade generator
// depends on alfg_pkg; watches the request, result and register ports of the block
`timescale 1ns / 1ps

module alfg_checker
  import alfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  in_t         req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  out_t        rsp_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending,
  output int          worked,
  output int          colours,
  output int          wraps,
  output int          finishes
);

  // register copy
  logic [23:0] dur_cfg;
  logic [31:0] start_cfg;
  logic [31:0] end_cfg;
  logic [3:0]  mask_cfg;
  logic        bounce_cfg;
  logic        restart_cfg;

  // fade state
  logic [23:0] time_left;
  logic [31:0] from_now;
  logic [31:0] to_now;
  logic        running;

  out_t colour_q[$];

  // to + floor((from - to) * rem / dur), zero duration gives the to colour
  function automatic logic [7:0] mix_channel(input logic [7:0] f, input logic [7:0] t,
                                             input logic [23:0] rem, input logic [23:0] dur);
    longint prod;
    longint d;
    longint q;
    longint v;
    if (dur == 24'd0) return t;
    d = longint'(dur);
    prod = (longint'(f) - longint'(t)) * longint'(rem);
    if (prod >= 0) q = prod / d;
    else q = -((-prod + d - 1) / d);
    v = longint'(t) + q;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, fname, want, got);
    end
  endtask

  task automatic advance_fade(input in_t r);
    logic [23:0] rem;
    logic [31:0] swap_c;
    out_t want;
    if (r.command == CMD_START) begin
      time_left = dur_cfg;
      from_now = start_cfg;
      to_now = end_cfg;
      running = 1'b1;
      worked++;
    end else if (running) begin
      worked++;
      time_left = (time_left > {8'd0, r.elapsed_ms}) ? time_left - {8'd0, r.elapsed_ms} : '0;
      rem = (time_left > dur_cfg) ? dur_cfg : time_left;
      want.alpha_out = mask_cfg[3] ? mix_channel(from_now[31:24], to_now[31:24], rem, dur_cfg)
                                   : 8'd0;
      want.red_out   = mask_cfg[2] ? mix_channel(from_now[23:16], to_now[23:16], rem, dur_cfg)
                                   : 8'd0;
      want.green_out = mask_cfg[1] ? mix_channel(from_now[15:8], to_now[15:8], rem, dur_cfg)
                                   : 8'd0;
      want.blue_out  = mask_cfg[0] ? mix_channel(from_now[7:0], to_now[7:0], rem, dur_cfg)
                                   : 8'd0;
      want.write_mask = mask_cfg;
      want.pass_wrapped = 1'b0;
      want.finished = 1'b0;
      if (time_left == 24'd0) begin
        if (bounce_cfg) begin
          swap_c = to_now;
          to_now = from_now;
          from_now = swap_c;
          time_left = dur_cfg;
          want.pass_wrapped = 1'b1;
          wraps++;
        end else if (restart_cfg) begin
          time_left = dur_cfg;
          want.pass_wrapped = 1'b1;
          wraps++;
        end else begin
          running = 1'b0;
          want.finished = 1'b1;
          finishes++;
        end
      end
      colour_q.push_back(want);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      dur_cfg = DURATION_RESET;
      start_cfg = START_RESET;
      end_cfg = END_RESET;
      mask_cfg = MASK_RESET;
      bounce_cfg = 1'b0;
      restart_cfg = 1'b0;
      time_left = '0;
      from_now = '0;
      to_now = '0;
      running = 1'b0;
      colour_q.delete();
      fails = 0;
      worked = 0;
      colours = 0;
      wraps = 0;
      finishes = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DURATION: dur_cfg = pwdata[23:0];
          REG_START:    start_cfg = pwdata;
          REG_END:      end_cfg = pwdata;
          REG_MASK:     mask_cfg = pwdata[3:0];
          REG_BOUNCE:   bounce_cfg = pwdata[0];
          REG_RESTART:  restart_cfg = pwdata[0];
          default: ;
        endcase
      end
      // a result accepted alongside a new request belongs to an older one
      if (rsp_valid && rsp_ready) begin
        if (colour_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing outstanding: %p", $time, rsp_data);
        end else begin
          want = colour_q.pop_front();
          colours++;
          cmp_field("alpha_out", want.alpha_out, rsp_data.alpha_out);
          cmp_field("red_out", want.red_out, rsp_data.red_out);
          cmp_field("green_out", want.green_out, rsp_data.green_out);
          cmp_field("blue_out", want.blue_out, rsp_data.blue_out);
          cmp_field("write_mask", {4'd0, want.write_mask}, {4'd0, rsp_data.write_mask});
          cmp_field("pass_wrapped", {7'd0, want.pass_wrapped}, {7'd0, rsp_data.pass_wrapped});
          cmp_field("finished", {7'd0, want.finished}, {7'd0, rsp_data.finished});
        end
      end
      if (req_valid && req_ready) advance_fade(req_data);
    end
    pending = colour_q.size();
  end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for argb_linear_fade_generator_unit
// depends on alfg_pkg, the block itself and alfg_checker, which predicts and compares
`timescale 1ns / 1ps

module tb;
  import alfg_pkg::*;

  localparam int SETTLE_CYCLES = 80;    // time for the block to go quiet, plus margin for a stalled result
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off so the block backs up
  localparam int STALL_LIMIT   = 4000;  // watchdog: cycles with no request or result moving
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 90;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  in_t         req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  out_t        rsp_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int worked;
  int colours;
  int wraps;
  int finishes;

  // idling knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_on = 1'b0;
  int settings_used = 0;
  int stall_count = 0;

  // duration as last written, used to scale elapsed times so passes end
  logic [23:0] cur_dur = DURATION_RESET;

  argb_linear_fade_generator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  alfg_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .fails    (fails),
    .pending  (pending),
    .worked   (worked),
    .colours  (colours),
    .wraps    (wraps),
    .finishes (finishes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any cycle that moves a request or a result clears the count
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d colours outstanding",
               STALL_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_on && !held) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // one request: optional idle cycles, then hold valid until accepted
  task automatic send_req(input logic cmd, input logic [15:0] elapsed);
    in_t it;
    it.command = cmd;
    it.elapsed_ms = elapsed;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_data <= it;
    do @(posedge clk); while (!req_ready);
  endtask

  // apb write: setup cycle then access cycle, register taken on the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_DURATION) cur_dur = val[23:0];
  endtask

  task automatic set_fade(input logic [23:0] dur, input logic [31:0] from_c,
                          input logic [31:0] to_c, input logic [3:0] mask,
                          input logic bounce, input logic restart);
    write_reg(REG_DURATION, {8'd0, dur});
    write_reg(REG_START, from_c);
    write_reg(REG_END, to_c);
    write_reg(REG_MASK, {28'd0, mask});
    write_reg(REG_BOUNCE, {31'd0, bounce});
    write_reg(REG_RESTART, {31'd0, restart});
    settings_used++;
  endtask

  // stop offering, drain every outstanding colour, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly a start followed by a run of ticks; sometimes ticks alone, which
  // either extend the current fade or fall on a stopped one
  task automatic run_sequence();
    int n;
    int r;
    int lim;
    if ($urandom_range(0, 99) >= 8) send_req(CMD_START, 16'($urandom));
    n = $urandom_range(2, 16);
    repeat (n) begin
      r = $urandom_range(0, 99);
      lim = cur_dur / 3 + 1;
      if (lim > 65535) lim = 65535;
      if (r < 8) send_req(CMD_TICK, 16'd0);
      else if (r < 14) send_req(CMD_TICK, 16'hFFFF);
      else if (r < 24) send_req(CMD_TICK, 16'($urandom));
      else send_req(CMD_TICK, 16'($urandom_range(0, lim)));
    end
  endtask

  initial begin
    int r;
    int phase_end;
    logic [23:0] dur;
    logic [31:0] from_c;
    logic [31:0] to_c;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: tick while stopped, then a full fade on the reset settings;
    // elapsed is ignored on start, the last tick falls on a finished fade
    send_req(CMD_TICK, 16'd5);
    send_req(CMD_START, 16'hFFFF);
    send_req(CMD_TICK, 16'd0);
    send_req(CMD_TICK, 16'd250);
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_TICK, 16'd1);
    settle();

    // zero duration: every tick ends the pass on the to colour, restart wraps;
    // two channels disabled
    set_fade(24'd0, 32'hA5C3_0F81, 32'h3C5A_F018, 4'b1010, 1'b0, 1'b1);
    send_req(CMD_START, 16'd0);
    send_req(CMD_TICK, 16'd0);
    send_req(CMD_TICK, 16'h8000);
    settle();

    // longest duration, white to black, bounce and restart both set
    set_fade(24'hFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'hF, 1'b1, 1'b1);
    send_req(CMD_START, 16'h1234);
    send_req(CMD_TICK, 16'hFFFF);
    send_req(CMD_TICK, 16'd0);
    settle();

    // duration lowered mid-fade: remaining time above it, ratio saturates
    write_reg(REG_DURATION, 32'd3);
    send_req(CMD_TICK, 16'd1);
    send_req(CMD_TICK, 16'h5555);
    // short passes: bounce wins over restart, endpoints swap each pass
    send_req(CMD_START, 16'd0);
    send_req(CMD_TICK, 16'd2);
    send_req(CMD_TICK, 16'd5);
    send_req(CMD_TICK, 16'd3);
    settle();

    // no looping and every channel masked off: the fade stops with all zero
    write_reg(REG_BOUNCE, 32'd0);
    write_reg(REG_RESTART, 32'd0);
    write_reg(REG_MASK, 32'd0);
    send_req(CMD_TICK, 16'hAAAA);
    send_req(CMD_TICK, 16'd9);
    settle();

    // random phases, each with its own settings and idling profile
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(0, 99);
      if (r < 45) dur = 24'($urandom_range(1, 40));
      else if (r < 80) dur = 24'($urandom_range(41, 4000));
      else if (r < 90) dur = 24'hFF_FFFF;
      else dur = 24'($urandom_range(1, 24'hFF_FFFF));
      from_c = ($urandom_range(0, 9) == 0) ? 32'h0000_0000 : $urandom;
      to_c = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
      set_fade(dur, from_c, to_c, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));

      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 46;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 46;
        end
        default: begin
          idle_pct = 18;
          stall_pct = 18;
        end
      endcase

      // one phase with a long hold-off on the result side while requests keep coming
      if (p == 4) hold_on = 1'b1;

      phase_end = worked + PHASE_ITEMS;
      while (worked < phase_end) run_sequence();
      settle();
    end

    idle_pct = 0;
    stall_pct = 0;
    $display("covered %0d requests acted on, %0d colours checked over %0d register settings",
             worked, colours, settings_used + 1);
    $display("passes wrapped by a loop: %0d, fades run to the end: %0d", wraps, finishes);
    if (fails == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d colours never arrived", fails, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
